FILE: sv/bae_pkg.sv
// ----------------------------------------------------------------------------
// Beacon extractor package
// Types and constants shared by the advertising beacon extractor modules.
// ----------------------------------------------------------------------------
package bae_pkg;

    localparam int ID_BYTES = 16;
    localparam int ID_BITS = ID_BYTES * 8;
    localparam int HALF_ID_BITS = ID_BITS / 2;

    localparam logic [7:0] MFG_TYPE = 8'hFF;
    localparam logic [4:0] ID_OFFSET = 5'd4;
    localparam logic [4:0] HALF_ID_END = 5'(4 + ID_BYTES / 2);
    localparam logic [4:0] MAJOR_OFFSET = 5'(4 + ID_BYTES);
    localparam logic [4:0] BODY_MIN = 5'(4 + ID_BYTES + 5);

    localparam logic [4:0] BODY_CO_LO = 5'd0;
    localparam logic [4:0] BODY_CO_HI = 5'd1;
    localparam logic [4:0] BODY_KIND = 5'd2;
    localparam logic [4:0] BODY_SIZE = 5'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPANY_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_KIND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_BODY_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_ID_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_ID_LOW = 3'd4;

    localparam logic [15:0] RST_COMPANY_CODE = 16'd76;
    localparam logic [7:0] RST_BEACON_KIND = 8'd2;
    localparam logic [7:0] RST_BEACON_BODY_SIZE = 8'd21;

    typedef enum logic [3:0] {
        PH_LEN = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic last_byte;
    } t_in;

    typedef struct packed {
        logic found;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [15:0] major_value;
        logic [15:0] minor_value;
        logic signed [7:0] cal_power;
        logic id_is_reference;
    } t_out;

    typedef struct packed {
        logic [15:0] company_code;
        logic [7:0] beacon_kind;
        logic [7:0] beacon_body_size;
        logic [63:0] ref_id_high;
        logic [63:0] ref_id_low;
    } t_cfg;

endpackage

FILE: sv/bae_cfg_regs.sv
// ----------------------------------------------------------------------------
// Beacon extractor configuration registers
// Holds the match and reference registers, written one transaction at a time.
// ----------------------------------------------------------------------------
module bae_cfg_regs
    import bae_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COMPANY_CODE: n_cfg.company_code = i_cfg_data[15:0];
                REG_BEACON_KIND: n_cfg.beacon_kind = i_cfg_data[7:0];
                REG_BEACON_BODY_SIZE: n_cfg.beacon_body_size = i_cfg_data[7:0];
                REG_REF_ID_HIGH: n_cfg.ref_id_high = i_cfg_data;
                REG_REF_ID_LOW: n_cfg.ref_id_low = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.company_code <= RST_COMPANY_CODE;
            r_cfg.beacon_kind <= RST_BEACON_KIND;
            r_cfg.beacon_body_size <= RST_BEACON_BODY_SIZE;
            r_cfg.ref_id_high <= '0;
            r_cfg.ref_id_low <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/bae_parser.sv
// ----------------------------------------------------------------------------
// Beacon extractor structure parser
// Walks length/type structures byte by byte and captures a matching beacon.
// ----------------------------------------------------------------------------
module bae_parser
    import bae_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_res
);

    t_phase r_phase;
    logic [7:0] r_field_left;
    logic r_field_is_mfg;
    logic [4:0] r_body_idx;
    logic r_header_ok;
    logic [HALF_ID_BITS-1:0] r_pend_id_hi;
    logic [HALF_ID_BITS-1:0] r_pend_id_lo;
    logic [39:0] r_pend_mmt;
    logic r_res_found;
    logic [HALF_ID_BITS-1:0] r_res_id_hi;
    logic [HALF_ID_BITS-1:0] r_res_id_lo;
    logic [39:0] r_res_mmt;

    t_phase n_phase;
    logic [7:0] n_field_left;
    logic n_field_is_mfg;
    logic [4:0] n_body_idx;
    logic n_header_ok;
    logic [HALF_ID_BITS-1:0] n_pend_id_hi;
    logic [HALF_ID_BITS-1:0] n_pend_id_lo;
    logic [39:0] n_pend_mmt;
    logic n_res_found;
    logic [HALF_ID_BITS-1:0] n_res_id_hi;
    logic [HALF_ID_BITS-1:0] n_res_id_lo;
    logic [39:0] n_res_mmt;

    logic [7:0] b;
    logic [7:0] left_dec;

    assign b = i_item.data_byte;
    assign left_dec = r_field_left - 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_field_left = r_field_left;
        n_field_is_mfg = r_field_is_mfg;
        n_body_idx = r_body_idx;
        n_header_ok = r_header_ok;
        n_pend_id_hi = r_pend_id_hi;
        n_pend_id_lo = r_pend_id_lo;
        n_pend_mmt = r_pend_mmt;
        n_res_found = r_res_found;
        n_res_id_hi = r_res_id_hi;
        n_res_id_lo = r_res_id_lo;
        n_res_mmt = r_res_mmt;

        case (r_phase)
            PH_LEN: begin
                if (b == 8'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_field_left = b;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_field_is_mfg = (b == MFG_TYPE);
                n_field_left = left_dec;
                n_body_idx = '0;
                n_header_ok = 1'b1;
                n_pend_id_hi = '0;
                n_pend_id_lo = '0;
                n_pend_mmt = '0;
                n_phase = (left_dec == 8'd0) ? PH_LEN : PH_BODY;
            end
            PH_BODY: begin
                if (r_body_idx < BODY_MIN) begin
                    if (r_body_idx == BODY_CO_LO) begin
                        if (b != i_cfg.company_code[7:0]) n_header_ok = 1'b0;
                    end else if (r_body_idx == BODY_CO_HI) begin
                        if (b != i_cfg.company_code[15:8]) n_header_ok = 1'b0;
                    end else if (r_body_idx == BODY_KIND) begin
                        if (b != i_cfg.beacon_kind) n_header_ok = 1'b0;
                    end else if (r_body_idx == BODY_SIZE) begin
                        if (b != i_cfg.beacon_body_size) n_header_ok = 1'b0;
                    end else if (r_body_idx < HALF_ID_END) begin
                        n_pend_id_hi = {r_pend_id_hi[HALF_ID_BITS-9:0], b};
                    end else if (r_body_idx < MAJOR_OFFSET) begin
                        n_pend_id_lo = {r_pend_id_lo[HALF_ID_BITS-9:0], b};
                    end else begin
                        n_pend_mmt = {r_pend_mmt[31:0], b};
                    end
                    n_body_idx = r_body_idx + 5'd1;
                end
                n_field_left = left_dec;
                if (left_dec == 8'd0) begin
                    if (r_field_is_mfg && n_header_ok && n_body_idx >= BODY_MIN) begin
                        n_res_found = 1'b1;
                        n_res_id_hi = n_pend_id_hi;
                        n_res_id_lo = n_pend_id_lo;
                        n_res_mmt = n_pend_mmt;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        o_res.found = n_res_found;
        o_res.id_high = n_res_id_hi;
        o_res.id_low = n_res_id_lo;
        o_res.major_value = n_res_mmt[39:24];
        o_res.minor_value = n_res_mmt[23:8];
        o_res.cal_power = n_res_mmt[7:0];
        o_res.id_is_reference = n_res_found && (n_res_id_hi == i_cfg.ref_id_high)
                                && (n_res_id_lo == i_cfg.ref_id_low);

        if (i_item.last_byte) begin
            n_phase = PH_LEN;
            n_field_left = '0;
            n_field_is_mfg = 1'b0;
            n_body_idx = '0;
            n_header_ok = 1'b1;
            n_pend_id_hi = '0;
            n_pend_id_lo = '0;
            n_pend_mmt = '0;
            n_res_found = 1'b0;
            n_res_id_hi = '0;
            n_res_id_lo = '0;
            n_res_mmt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_field_left <= '0;
            r_field_is_mfg <= 1'b0;
            r_body_idx <= '0;
            r_header_ok <= 1'b1;
            r_pend_id_hi <= '0;
            r_pend_id_lo <= '0;
            r_pend_mmt <= '0;
            r_res_found <= 1'b0;
            r_res_id_hi <= '0;
            r_res_id_lo <= '0;
            r_res_mmt <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_field_left <= n_field_left;
            r_field_is_mfg <= n_field_is_mfg;
            r_body_idx <= n_body_idx;
            r_header_ok <= n_header_ok;
            r_pend_id_hi <= n_pend_id_hi;
            r_pend_id_lo <= n_pend_id_lo;
            r_pend_mmt <= n_pend_mmt;
            r_res_found <= n_res_found;
            r_res_id_hi <= n_res_id_hi;
            r_res_id_lo <= n_res_id_lo;
            r_res_mmt <= n_res_mmt;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.last_byte) |=> (r_phase == PH_LEN && !r_res_found))
        else $error("Parser state not cleared after the final byte.");

    a_body_idx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_body_idx <= BODY_MIN)
        else $error("Body index passed its saturation value.");

    a_found_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_found |-> (r_phase == PH_DONE))
        else $error("Parsing continued after a match.");

endmodule

FILE: sv/ble_adv_beacon_extractor.sv
// ----------------------------------------------------------------------------
// Advertising beacon extractor
// Parses advertising payload bytes and reports the first matching beacon.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  input     in         i_valid / o_stall       i_item (t_in)
//  result    out        o_valid / i_stall       o_res (t_out)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  One byte is accepted per cycle while o_stall is low; it is parsed from r_in.
//  The result of a payload is registered into r_out as its final byte is parsed.
//  Reset is synchronous and restores the register defaults and parse state.
//  A held result stalls only the final byte of the next payload.
// ----------------------------------------------------------------------------
module ble_adv_beacon_extractor
    import bae_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_cfg cfg;
    t_out res;
    logic r_in_valid;
    t_in r_in;
    logic r_out_valid;
    t_out r_out;
    logic out_free;
    logic proc;

    bae_cfg_regs u_cfg (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_cfg(cfg)
    );

    bae_parser u_parser (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(proc),
        .i_item(r_in),
        .i_cfg(cfg),
        .o_res(res)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign proc = r_in_valid && (!r_in.last_byte || out_free);
    assign o_stall = r_in_valid && !proc;
    assign o_valid = r_out_valid;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= proc && r_in.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
        if (proc && r_in.last_byte) begin
            r_out <= res;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in.last_byte))
        else $error("Input stalled without a held final byte.");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.last_byte) |=> o_valid)
        else $error("Final byte parsed without a result transaction.");

    a_ref_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.id_is_reference) |-> o_res.found)
        else $error("Reference match reported without a found beacon.");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertising beacon extractor testbench
// Streams advertising payloads through the extractor under random idling on
// both sides. A self-contained parser in the bench predicts each result, and
// the monitor compares every result transaction field by field. Short directed
// payloads come first, then random payloads under several register settings.
// ----------------------------------------------------------------------------
module tb;
    import bae_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in                  i_item;
    logic                 o_valid;
    logic                 i_stall;
    t_out                 o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    ble_adv_beacon_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_in         pending_bytes[$];
    t_out        expected_beacons[$];
    logic [7:0]  frame_bytes[$];
    int          fed_items = 0;
    int          fed_frames = 0;
    int          error_count = 0;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          recv_calm = 0;
    int          quiet_cycles = 0;

    t_cfg        cfg_now;
    t_phase      parse_phase;
    logic [7:0]  owed;
    logic        is_mfg;
    logic [4:0]  body_seen;
    logic        header_match;
    logic [127:0] cap_id;
    logic [39:0] cap_tail;
    t_out        beacon_held;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void restart_parse();
        parse_phase = PH_LEN;
        owed = 8'd0;
        is_mfg = 1'b0;
        body_seen = 5'd0;
        header_match = 1'b1;
        cap_id = '0;
        cap_tail = '0;
        beacon_held = '0;
    endfunction

    function automatic void predict_byte(t_in item);
        logic [7:0] b;
        b = item.data_byte;
        case (parse_phase)
            PH_LEN: begin
                if (b == 8'd0) begin
                    parse_phase = PH_DONE;
                end else begin
                    owed = b;
                    parse_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                is_mfg = (b == MFG_TYPE);
                owed = owed - 8'd1;
                body_seen = 5'd0;
                header_match = 1'b1;
                cap_id = '0;
                cap_tail = '0;
                parse_phase = (owed == 8'd0) ? PH_LEN : PH_BODY;
            end
            PH_BODY: begin
                if (body_seen < BODY_MIN) begin
                    case (body_seen)
                        BODY_CO_LO: if (b != cfg_now.company_code[7:0]) header_match = 1'b0;
                        BODY_CO_HI: if (b != cfg_now.company_code[15:8]) header_match = 1'b0;
                        BODY_KIND: if (b != cfg_now.beacon_kind) header_match = 1'b0;
                        BODY_SIZE: if (b != cfg_now.beacon_body_size) header_match = 1'b0;
                        default: begin
                            if (body_seen < MAJOR_OFFSET) cap_id = {cap_id[119:0], b};
                            else cap_tail = {cap_tail[31:0], b};
                        end
                    endcase
                    body_seen = body_seen + 5'd1;
                end
                owed = owed - 8'd1;
                if (owed == 8'd0) begin
                    if (is_mfg && header_match && body_seen >= BODY_MIN) begin
                        beacon_held.found = 1'b1;
                        beacon_held.id_high = cap_id[127:64];
                        beacon_held.id_low = cap_id[63:0];
                        beacon_held.major_value = cap_tail[39:24];
                        beacon_held.minor_value = cap_tail[23:8];
                        beacon_held.cal_power = cap_tail[7:0];
                        parse_phase = PH_DONE;
                    end else begin
                        parse_phase = PH_LEN;
                    end
                end
            end
            default: ;
        endcase
        if (item.last_byte) begin
            beacon_held.id_is_reference = beacon_held.found &&
                {beacon_held.id_high, beacon_held.id_low} ==
                {cfg_now.ref_id_high, cfg_now.ref_id_low};
            expected_beacons.push_back(beacon_held);
            restart_parse();
        end
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_result(t_out got);
        t_out want;
        if (expected_beacons.size() == 0) begin
            $error("result transaction with no expectation outstanding");
            error_count++;
        end else begin
            want = expected_beacons.pop_front();
            compare_field("found", 64'(want.found), 64'(got.found));
            compare_field("id_high", want.id_high, got.id_high);
            compare_field("id_low", want.id_low, got.id_low);
            compare_field("major_value", 64'(want.major_value), 64'(got.major_value));
            compare_field("minor_value", 64'(want.minor_value), 64'(got.minor_value));
            compare_field("cal_power", 64'($unsigned(want.cal_power)),
                          64'($unsigned(got.cal_power)));
            compare_field("id_is_reference", 64'(want.id_is_reference),
                          64'(got.id_is_reference));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
            send_calm <= 0;
        end else begin
            if (i_valid && !o_stall) predict_byte(i_item);
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_bytes.size() > 0) begin
                    i_item <= pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    if (send_calm > 0) begin
                        send_calm <= send_calm - 1;
                        send_gap <= 0;
                    end else begin
                        send_gap <= draw_gap();
                        if ($urandom_range(0, 63) == 0) send_calm <= $urandom_range(20, 80);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
            recv_calm <= 0;
        end else begin
            if (o_valid && !i_stall) check_result(o_res);
            if (hold_seen != hold_asked) begin
                hold_seen <= hold_asked;
                i_stall <= 1'b1;
                stall_left <= HOLD_CYCLES;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if (recv_calm > 0) begin
                    recv_calm <= recv_calm - 1;
                end else begin
                    stall_left <= draw_gap();
                    if ($urandom_range(0, 63) == 0) recv_calm <= $urandom_range(20, 80);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ble_adv_beacon_extractor regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COMPANY_CODE: cfg_now.company_code = value[15:0];
            REG_BEACON_KIND: cfg_now.beacon_kind = value[7:0];
            REG_BEACON_BODY_SIZE: cfg_now.beacon_body_size = value[7:0];
            REG_REF_ID_HIGH: cfg_now.ref_id_high = value;
            REG_REF_ID_LOW: cfg_now.ref_id_low = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] company, logic [7:0] kind, logic [7:0] size,
                             logic [63:0] ref_high, logic [63:0] ref_low);
        write_reg(REG_COMPANY_CODE, 64'(company));
        write_reg(REG_BEACON_KIND, 64'(kind));
        write_reg(REG_BEACON_BODY_SIZE, 64'(size));
        write_reg(REG_REF_ID_HIGH, ref_high);
        write_reg(REG_REF_ID_LOW, ref_low);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_beacons.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frame(bit may_cut);
        int keep;
        t_in item;
        keep = frame_bytes.size();
        if (may_cut && $urandom_range(0, 7) == 0) keep = $urandom_range(1, keep);
        for (int k = 0; k < keep; k++) begin
            item.data_byte = frame_bytes[k];
            item.last_byte = (k == keep - 1);
            pending_bytes.push_back(item);
        end
        fed_items += keep;
        fed_frames++;
        frame_bytes.delete();
    endtask

    task automatic add_other();
        int len;
        len = $urandom_range(1, 10);
        frame_bytes.push_back(8'(len));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (len - 1) frame_bytes.push_back(pick_byte());
    endtask

    task automatic add_beacon();
        logic [7:0]   body[$];
        logic [127:0] ident;
        int           body_count;
        int           pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) body_count = 254;
        else if (pick < 4) body_count = $urandom_range(20, 24);
        else if (pick < 10) body_count = $urandom_range(26, 40);
        else body_count = 25;
        ident = {cfg_now.ref_id_high, cfg_now.ref_id_low};
        pick = $urandom_range(0, 5);
        if (pick == 1) begin
            ident[8 * $urandom_range(0, 15) +: 8] ^= 8'($urandom_range(1, 255));
        end else if (pick > 1) begin
            for (int k = 0; k < 16; k++) ident[8 * k +: 8] = pick_byte();
        end
        body.push_back(cfg_now.company_code[7:0]);
        body.push_back(cfg_now.company_code[15:8]);
        body.push_back(cfg_now.beacon_kind);
        body.push_back(cfg_now.beacon_body_size);
        for (int k = 15; k >= 0; k--) body.push_back(ident[8 * k +: 8]);
        while (body.size() < body_count) body.push_back(pick_byte());
        if ($urandom_range(0, 5) == 0) body[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        frame_bytes.push_back(8'(body_count + 1));
        frame_bytes.push_back(MFG_TYPE);
        for (int k = 0; k < body_count; k++) frame_bytes.push_back(body[k]);
    endtask

    task automatic build_payload();
        int shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) add_other();
            if (shape != 1) add_beacon();
            if ($urandom_range(0, 3) == 0) add_beacon();
            repeat ($urandom_range(0, 2)) add_other();
            if ($urandom_range(0, 3) == 0) begin
                frame_bytes.push_back(8'h00);
                repeat ($urandom_range(0, 4)) frame_bytes.push_back(pick_byte());
            end
        end
        if (frame_bytes.size() == 0) frame_bytes.push_back(pick_byte());
        send_frame(1'b1);
    endtask

    task automatic random_payloads(int item_goal, int frame_goal);
        int items_from;
        int frames_from;
        items_from = fed_items;
        frames_from = fed_frames;
        while (fed_items - items_from < item_goal || fed_frames - frames_from < frame_goal)
            build_payload();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_now = '{company_code: RST_COMPANY_CODE, beacon_kind: RST_BEACON_KIND,
                    beacon_body_size: RST_BEACON_BODY_SIZE, ref_id_high: 64'd0,
                    ref_id_low: 64'd0};
        restart_parse();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        frame_bytes = '{8'h00};
        send_frame(1'b0);
        frame_bytes = '{8'h02, MFG_TYPE};
        send_frame(1'b0);
        frame_bytes = '{8'h01, 8'h16, 8'h00, 8'h5A};
        send_frame(1'b0);
        frame_bytes = '{8'h05};
        send_frame(1'b0);
        frame_bytes = '{8'hFF, MFG_TYPE, 8'h4C, 8'h00, 8'h02};
        send_frame(1'b0);
        frame_bytes = '{8'h03, MFG_TYPE, 8'h4C, 8'h00, 8'h00, 8'hFF};
        send_frame(1'b0);
        random_payloads(180, 10);
        wait_drained();

        write_all(16'hFFFF, 8'hFF, 8'hFF, {64{1'b1}}, {$urandom, $urandom});
        random_payloads(200, 12);
        hold_asked++;
        wait_drained();

        write_all(16'h0000, 8'h00, 8'h00, 64'd0, 64'd0);
        random_payloads(200, 12);
        wait_drained();

        write_all(16'($urandom), 8'($urandom), 8'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom});
        random_payloads(200, 12);
        wait_drained();

        if (error_count == 0) begin
            $display("ble_adv_beacon_extractor regression: pass");
        end else begin
            $display("ble_adv_beacon_extractor regression: fail");
        end
        $finish;
    end

endmodule

FILE: ble_adv_beacon_extractor.f
sv/bae_pkg.sv
sv/bae_cfg_regs.sv
sv/bae_parser.sv
sv/ble_adv_beacon_extractor.sv
test/tb.sv
